// ----- hw/rtl/pip_pkg.sv -----
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Command codes, controller states and the control and status groups that
// pass between the controller and the edge unit.
// ----------------------------------------------------------------------------
package pip_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEST   = 2'd2
  } cmd_e_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_WALK  = 2'd1,
    S_DRAIN = 2'd2
  } state_t;

  typedef struct packed {
    logic feed;
    logic restart;
  } edge_ctrl_t;

  typedef struct packed {
    logic pending;
  } edge_stat_t;

endpackage

// ----- hw/rtl/pip_cell.sv -----
// ----------------------------------------------------------------------------
// Vertex cell
// Holds one polygon vertex. Loads it on an append aimed at its slot and,
// during a point test, takes the vertex of its right neighbor so that the
// stored vertices rotate past the head of the row.
// ----------------------------------------------------------------------------
module pip_cell #(
  parameter int COORD_BITS = 16,
  parameter int CNT_W      = 7,
  parameter int INDEX      = 0
) (
  input  logic                         clk,
  input  logic                         append,
  input  logic                         shift,
  input  logic [CNT_W-1:0]             count,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  logic signed [COORD_BITS-1:0] nbr_x,
  input  logic signed [COORD_BITS-1:0] nbr_y,
  input  logic signed [COORD_BITS-1:0] first_x,
  input  logic signed [COORD_BITS-1:0] first_y,
  output logic signed [COORD_BITS-1:0] vx,
  output logic signed [COORD_BITS-1:0] vy
);

  logic is_slot;
  logic is_tail;

  assign is_slot = (count == CNT_W'(INDEX));
  assign is_tail = (count - CNT_W'(1) == CNT_W'(INDEX));

  always_ff @(posedge clk) begin
    if (append && is_slot) begin
      vx <= wr_x;
      vy <= wr_y;
    end else if (shift) begin
      if (is_tail) begin
        vx <= first_x;
        vy <= first_y;
      end else begin
        vx <= nbr_x;
        vy <= nbr_y;
      end
    end
  end

endmodule

// ----- hw/rtl/pip_edge.sv -----
// ----------------------------------------------------------------------------
// Edge crossing unit
// Three-stage pipeline that takes one polygon edge per cycle, decides
// whether the ray from the query point crosses it, and keeps the parity.
// ----------------------------------------------------------------------------
module pip_edge #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pip_pkg::edge_ctrl_t          ctrl,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output pip_pkg::edge_stat_t          stat,
  output logic                         odd
);

  import pip_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic                 skip;
  logic                 flip_next;
  logic                 cross_next;
  logic signed [DW-1:0] leftx;
  logic signed [DW-1:0] t1_next;
  logic signed [DW-1:0] t2_next;
  logic signed [DW-1:0] dx_raw;
  logic signed [DW-1:0] dy_raw;
  logic signed [DW-1:0] dx_next;
  logic signed [DW-1:0] dy_next;
  logic                 x_out;
  logic                 y_out;

  logic                 a_valid;
  logic                 a_flip;
  logic                 a_cross;
  logic signed [DW-1:0] a_t1;
  logic signed [DW-1:0] a_t2;
  logic signed [DW-1:0] a_dx;
  logic signed [DW-1:0] a_dy;

  logic                 b_valid;
  logic                 b_flip;
  logic                 b_cross;
  logic signed [PW-1:0] b_p;
  logic signed [PW-1:0] b_q;

  always_comb begin
    if (cx < px) begin
      x_out = (qx >= px);
      leftx = DW'(cx);
    end else begin
      x_out = (qx >= cx);
      leftx = DW'(px);
    end
    if (cy < py) begin
      y_out   = (qy < cy) || (qy >= py);
      t1_next = DW'(qx) - DW'(cx);
      t2_next = DW'(qy) - DW'(cy);
    end else begin
      y_out   = (qy < py) || (qy >= cy);
      t1_next = DW'(qx) - DW'(px);
      t2_next = DW'(qy) - DW'(py);
    end
    skip       = (cy == py) || x_out || y_out;
    flip_next  = !skip && (DW'(qx) < leftx);
    cross_next = !skip && !flip_next;
    dy_raw     = DW'(py) - DW'(cy);
    dx_raw     = DW'(px) - DW'(cx);
    if (dy_raw < 0) begin
      dy_next = -dy_raw;
      dx_next = -dx_raw;
    end else begin
      dy_next = dy_raw;
      dx_next = dx_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      odd     <= 1'b0;
    end else begin
      a_valid <= ctrl.feed;
      b_valid <= a_valid;
      if (ctrl.restart) begin
        odd <= 1'b0;
      end else if (b_valid && (b_flip || (b_cross && (b_p < b_q)))) begin
        odd <= ~odd;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_flip  <= flip_next;
    a_cross <= cross_next;
    a_t1    <= t1_next;
    a_t2    <= t2_next;
    a_dx    <= dx_next;
    a_dy    <= dy_next;
    b_flip  <= a_flip;
    b_cross <= a_cross;
    b_p     <= PW'(a_t1) * PW'(a_dy);
    b_q     <= PW'(a_t2) * PW'(a_dx);
  end

  assign stat.pending = a_valid || b_valid;

endmodule

// ----- hw/rtl/point_in_polygon_even_odd_core.sv -----
// ----------------------------------------------------------------------------
// Even-odd point-in-polygon core
// Keeps a polygon in a row of vertex cells with a running bounding box and
// tests query points against it by the even-odd crossing rule.
//
//   Channel   Signals                                  Handshake
//   --------  ---------------------------------------  ---------------------
//   command   command, coord_x, coord_y                start && !busy
//   result    inside_res, vertex_total, add_rejected,  done, one cycle,
//             box_min_x/y, box_max_x/y                 no back-pressure
//
// Clear, append and unused commands answer in the cycle after acceptance
// and leave busy low, so a new item may follow at once.
// A point test that reaches the edge walk answers once all edges have passed
// through the edge unit: the cells rotate one edge per cycle into the three-stage
// edge unit. Tests with fewer than three vertices or outside the box answer
// in the next cycle. Reset is synchronous and empties the polygon.
// ----------------------------------------------------------------------------
module point_in_polygon_even_odd_core #(
  parameter int  MAX_VERTICES = 64,
  parameter int  COORD_BITS   = 16,
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  output logic                         done,
  output logic                         inside_res,
  output logic [CNT_W-1:0]             vertex_total,
  output logic                         add_rejected,
  output logic signed [COORD_BITS-1:0] box_min_x,
  output logic signed [COORD_BITS-1:0] box_min_y,
  output logic signed [COORD_BITS-1:0] box_max_x,
  output logic signed [COORD_BITS-1:0] box_max_y
);

  import pip_pkg::*;

  state_t                       state;
  state_t                       state_next;
  edge_ctrl_t                   ectrl;
  edge_stat_t                   estat;
  logic                         odd;

  logic                         accept;
  logic                         is_clear;
  logic                         is_append;
  logic                         is_test;
  logic                         early;
  logic                         walk_go;
  logic                         last_step;

  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             step;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] max_y;
  logic signed [COORD_BITS-1:0] last_x;
  logic signed [COORD_BITS-1:0] last_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] qx;
  logic signed [COORD_BITS-1:0] qy;

  logic signed [COORD_BITS-1:0] vx [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] vy [MAX_VERTICES];

  assign accept    = start && !busy;
  assign is_clear  = (command == CMD_CLEAR);
  assign is_append = (command == CMD_APPEND);
  assign is_test   = (command == CMD_TEST);
  assign early     = (count < CNT_W'(3)) || (coord_x < min_x) || (coord_x >= max_x) ||
                     (coord_y < min_y) || (coord_y >= max_y);
  assign walk_go   = accept && is_test && !early;
  assign last_step = (step == count - CNT_W'(1));

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pip_cell #(
      .COORD_BITS(COORD_BITS),
      .CNT_W     (CNT_W),
      .INDEX     (i)
    ) u_cell (
      .clk    (clk),
      .append (accept && is_append),
      .shift  (ectrl.feed),
      .count  (count),
      .wr_x   (coord_x),
      .wr_y   (coord_y),
      .nbr_x  (vx[(i + 1) % MAX_VERTICES]),
      .nbr_y  (vy[(i + 1) % MAX_VERTICES]),
      .first_x(vx[0]),
      .first_y(vy[0]),
      .vx     (vx[i]),
      .vy     (vy[i])
    );
  end

  pip_edge #(
    .COORD_BITS(COORD_BITS)
  ) u_edge (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ectrl),
    .qx   (qx),
    .qy   (qy),
    .px   (prev_x),
    .py   (prev_y),
    .cx   (vx[0]),
    .cy   (vy[0]),
    .stat (estat),
    .odd  (odd)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (walk_go) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (last_step) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!estat.pending) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = (state != S_IDLE);
    ectrl.feed    = (state == S_WALK);
    ectrl.restart = walk_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      count <= '0;
      min_x <= '0;
      min_y <= '0;
      max_x <= '0;
      max_y <= '0;
    end else begin
      state <= state_next;
      done  <= (accept && !walk_go) || (state == S_DRAIN && !estat.pending);
      if (accept && is_clear) begin
        count <= '0;
        min_x <= '0;
        min_y <= '0;
        max_x <= '0;
        max_y <= '0;
      end else if (accept && is_append && count != CNT_W'(MAX_VERTICES)) begin
        count <= count + CNT_W'(1);
        if (count == '0) begin
          min_x <= coord_x;
          max_x <= coord_x;
          min_y <= coord_y;
          max_y <= coord_y;
        end else begin
          if (coord_x < min_x) begin
            min_x <= coord_x;
          end
          if (coord_x > max_x) begin
            max_x <= coord_x;
          end
          if (coord_y < min_y) begin
            min_y <= coord_y;
          end
          if (coord_y > max_y) begin
            max_y <= coord_y;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inside_res   <= 1'b0;
      add_rejected <= is_append && (count == CNT_W'(MAX_VERTICES));
      qx           <= coord_x;
      qy           <= coord_y;
    end else if (state == S_DRAIN && !estat.pending) begin
      inside_res <= odd;
    end
    if (accept && is_append && count != CNT_W'(MAX_VERTICES)) begin
      last_x <= coord_x;
      last_y <= coord_y;
    end
    if (walk_go) begin
      prev_x <= last_x;
      prev_y <= last_y;
      step   <= '0;
    end else if (ectrl.feed) begin
      prev_x <= vx[0];
      prev_y <= vy[0];
      step   <= step + CNT_W'(1);
    end
  end

  assign vertex_total = count;
  assign box_min_x    = min_x;
  assign box_min_y    = min_y;
  assign box_max_x    = max_x;
  assign box_max_y    = max_y;

endmodule
